[hdl/uuds_pkg.sv]
package uuds_pkg;

    localparam int LINE_LIMIT   = 126;
    localparam int TOTAL_BITS   = 24;
    localparam int LINE_CHARS_W = $clog2(LINE_LIMIT + 1);

    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;
    localparam logic [7:0] CHAR_COUNT_MAX = 8'd77;
    localparam logic [7:0] CHAR_DATA_MAX  = 8'd96;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } t_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        t_kind       kind;
        logic [23:0] byte_total;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      n_data;
        logic            err;
        logic            eot;
    } t_bundle;

endpackage

[hdl/uuds_decoder.sv]
module uuds_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  uuds_pkg::t_item  i_item,
    input  logic             i_seq_free,
    output logic             o_ready,
    output logic             o_load,
    output uuds_pkg::t_bundle o_bundle
);

    logic [uuds_pkg::LINE_CHARS_W-1:0] r_line_chars, n_line_chars;
    logic                              r_line_active, n_line_active;
    logic [5:0]                        r_bytes_left, n_bytes_left;
    logic [1:0]                        r_group_slot, n_group_slot;
    logic [3:0][5:0]                   r_group_bits, n_group_bits;
    logic                              r_group_broken, n_group_broken;
    logic                              r_failed, n_failed;

    uuds_pkg::t_bundle bundle;
    logic [7:0]        c;
    logic              broken_now;
    logic [5:0]        sextet;
    logic [3:0][5:0]   full_group;
    logic [1:0]        emit_count;
    logic              produces;
    logic              accept;

    assign emit_count = (r_bytes_left >= 6'd3) ? 2'd3 : r_bytes_left[1:0];
    assign c          = i_item.text_char;
    assign broken_now = r_group_broken || (c < uuds_pkg::CHAR_SPACE)
                        || (c > uuds_pkg::CHAR_DATA_MAX);
    assign sextet     = broken_now ? 6'd0 : (c[5:0] - 6'd32);

    always_comb begin
        full_group    = r_group_bits;
        full_group[3] = sextet;
    end

    always_comb begin
        n_line_chars   = r_line_chars;
        n_line_active  = r_line_active;
        n_bytes_left   = r_bytes_left;
        n_group_slot   = r_group_slot;
        n_group_bits   = r_group_bits;
        n_group_broken = r_group_broken;
        n_failed       = r_failed;
        bundle.bytes   = r_group_bits;
        bundle.n_data  = 2'd0;
        bundle.err     = 1'b0;
        bundle.eot     = 1'b0;

        if (i_item.end_of_text) begin
            if (!r_failed && r_line_active && (r_group_slot != 2'd0)) begin
                bundle.n_data = emit_count;
            end
            bundle.eot     = 1'b1;
            n_line_chars   = '0;
            n_line_active  = 1'b0;
            n_bytes_left   = 6'd0;
            n_group_slot   = 2'd0;
            n_group_bits   = '0;
            n_group_broken = 1'b0;
            n_failed       = 1'b0;
        end else if (r_failed) begin
            n_failed = 1'b1;
        end else if (c == uuds_pkg::CHAR_NEWLINE) begin
            if (r_line_active && (r_group_slot != 2'd0)) begin
                bundle.n_data = emit_count;
            end
            n_line_chars   = '0;
            n_line_active  = 1'b0;
            n_bytes_left   = 6'd0;
            n_group_slot   = 2'd0;
            n_group_bits   = '0;
            n_group_broken = 1'b0;
        end else if (r_line_chars >= uuds_pkg::LINE_CHARS_W'(uuds_pkg::LINE_LIMIT)) begin
            bundle.err     = 1'b1;
            n_failed       = 1'b1;
            n_line_chars   = '0;
            n_line_active  = 1'b0;
            n_bytes_left   = 6'd0;
            n_group_slot   = 2'd0;
            n_group_bits   = '0;
            n_group_broken = 1'b0;
        end else begin
            n_line_chars = r_line_chars + 1'b1;
            if (r_line_chars == '0) begin
                n_line_active = (c > uuds_pkg::CHAR_SPACE) && (c <= uuds_pkg::CHAR_COUNT_MAX);
                n_bytes_left  = n_line_active ? (c[5:0] - 6'd32) : 6'd0;
            end else if (r_line_active) begin
                if (r_group_slot == 2'd3) begin
                    bundle.bytes   = full_group;
                    bundle.n_data  = emit_count;
                    n_bytes_left   = r_bytes_left - {4'd0, emit_count};
                    n_group_slot   = 2'd0;
                    n_group_bits   = '0;
                    n_group_broken = 1'b0;
                end else begin
                    n_group_bits[r_group_slot] = sextet;
                    n_group_slot               = r_group_slot + 2'd1;
                    n_group_broken             = broken_now;
                end
            end
        end
    end

    assign produces = (bundle.n_data != 2'd0) || bundle.err || bundle.eot;
    assign o_ready  = i_seq_free || !produces;
    assign accept   = i_valid && o_ready;
    assign o_load   = accept && produces;
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_chars   <= '0;
            r_line_active  <= 1'b0;
            r_bytes_left   <= 6'd0;
            r_group_slot   <= 2'd0;
            r_group_bits   <= '0;
            r_group_broken <= 1'b0;
            r_failed       <= 1'b0;
        end else if (accept) begin
            r_line_chars   <= n_line_chars;
            r_line_active  <= n_line_active;
            r_bytes_left   <= n_bytes_left;
            r_group_slot   <= n_group_slot;
            r_group_bits   <= n_group_bits;
            r_group_broken <= n_group_broken;
            r_failed       <= n_failed;
        end
    end

endmodule

[hdl/uuds_sequencer.sv]
module uuds_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  uuds_pkg::t_bundle i_bundle,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output uuds_pkg::t_result o_result
);

    logic                            r_busy;
    logic [1:0]                      r_idx;
    logic [uuds_pkg::TOTAL_BITS-1:0] r_total;
    logic [2:0][7:0]                 r_bytes;
    logic [1:0]                      r_n_data;
    logic [2:0]                      r_count;
    logic                            r_err;

    logic                            take;
    logic                            last;
    logic                            is_data;
    logic [uuds_pkg::TOTAL_BITS-1:0] total_inc;

    assign take      = r_busy && i_ready;
    assign last      = ({1'b0, r_idx} + 3'd1) == r_count;
    assign is_data   = r_idx < r_n_data;
    assign total_inc = (r_total == uuds_pkg::TOTAL_MAX) ? r_total : (r_total + 1'b1);
    assign o_free    = !r_busy || (take && last);
    assign o_valid   = r_busy;

    always_comb begin
        o_result.last_of_run = last;
        if (is_data) begin
            o_result.out_byte   = r_bytes[r_idx];
            o_result.kind       = uuds_pkg::KIND_DATA;
            o_result.byte_total = 24'(total_inc);
        end else begin
            o_result.out_byte   = 8'd0;
            o_result.kind       = r_err ? uuds_pkg::KIND_ERROR : uuds_pkg::KIND_END;
            o_result.byte_total = 24'(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= 2'd0;
            r_total <= '0;
        end else begin
            if (take) begin
                if (is_data) begin
                    r_total <= total_inc;
                end else if (!r_err) begin
                    r_total <= '0;
                end
            end
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (take && last) begin
                r_busy <= 1'b0;
            end else if (take) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes  <= i_bundle.bytes;
            r_n_data <= i_bundle.n_data;
            r_err    <= i_bundle.err;
            r_count  <= {1'b0, i_bundle.n_data} + {2'b00, i_bundle.err || i_bundle.eot};
        end
    end

endmodule

[hdl/uudecode_stream_unit.sv]
// Streaming uudecoder: one character item is taken per clock, and each item yields
// between zero and four results (up to three data bytes followed by an end-of-text
// marker, or a single line-too-long error), delivered one per clock unless stalled, from
// a result register starting the cycle after the item is accepted. An item that yields
// no result is accepted even while earlier results drain, so a full four-character group
// sustains one character per cycle while the receiver keeps up; an item that yields
// results waits until the result register has handed over its last result. A newline
// after a partial group yields up to three results, and an end of text up to four.
module uudecode_stream_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  uuds_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output uuds_pkg::t_result o_result
);

    logic              seq_free;
    logic              load;
    uuds_pkg::t_bundle bundle;

    uuds_decoder u_decoder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .i_seq_free (seq_free),
        .o_ready    (o_ready),
        .o_load     (load),
        .o_bundle   (bundle)
    );

    uuds_sequencer u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_bundle (bundle),
        .o_free   (seq_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule

[hdl/uuds_checker.sv]
module uuds_assertions (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input uuds_pkg::t_result i_result
);

    // A stalled result item must hold still.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_result))
        else $error("result item changed while stalled");

    // The results of one input item follow each other without a gap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && !i_result.last_of_run |=> i_res_valid)
        else $error("gap inside a run of results");

    // Markers and errors always close their run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_result.kind != uuds_pkg::KIND_DATA) |->
            i_result.last_of_run && (i_result.out_byte == 8'd0))
        else $error("marker or error item malformed");

    // A data byte always counts itself in the total.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_result.kind == uuds_pkg::KIND_DATA) |->
            (i_result.byte_total != 24'd0))
        else $error("data item with zero total");

endmodule

bind uudecode_stream_unit uuds_assertions u_uuds_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_valid),
    .i_res_ready (i_ready),
    .i_result    (o_result)
);

[sim/uuds_checker.sv]
module uuds_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  uuds_pkg::t_item   i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  uuds_pkg::t_result i_out_result,
    output int                o_fail_count,
    output int                o_open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [uuds_pkg::LINE_CHARS_W-1:0] line_chars;
    logic                              line_active;
    logic [5:0]                        bytes_left;
    logic [2:0]                        group_slot;
    logic [23:0]                       group_bits;
    logic                              group_broken;
    logic [uuds_pkg::TOTAL_BITS-1:0]   running_total;
    logic                              failed;

    uuds_pkg::t_result decoded_q[$];
    uuds_pkg::t_result caused_q[$];
    int                mismatch_count = 0;

    function automatic void clear_line();
        line_chars   = '0;
        line_active  = 1'b0;
        bytes_left   = '0;
        group_slot   = '0;
        group_bits   = '0;
        group_broken = 1'b0;
    endfunction

    function automatic void push_result(logic [7:0] value, uuds_pkg::t_kind kind);
        uuds_pkg::t_result r;
        r.out_byte    = value;
        r.kind        = kind;
        r.byte_total  = running_total[23:0];
        r.last_of_run = 1'b0;
        caused_q.push_back(r);
    endfunction

    function automatic void flush_group();
        for (int j = 0; j < 3; j++) begin
            if (bytes_left != '0) begin
                bytes_left--;
                if (running_total != uuds_pkg::TOTAL_MAX) begin
                    running_total++;
                end
                push_result(group_bits[8*j +: 8], uuds_pkg::KIND_DATA);
            end
        end
        group_slot   = '0;
        group_bits   = '0;
        group_broken = 1'b0;
    endfunction

    function automatic void decode_char(uuds_pkg::t_item it);
        logic [7:0] c;
        logic [5:0] sextet;
        c = it.text_char;
        caused_q.delete();
        if (it.end_of_text) begin
            if (!failed && line_active && group_slot != '0) begin
                flush_group();
            end
            push_result(8'd0, uuds_pkg::KIND_END);
            clear_line();
            running_total = '0;
            failed        = 1'b0;
        end else if (failed) begin
            // After an overlong line everything is dropped until end of text.
        end else if (c == uuds_pkg::CHAR_NEWLINE) begin
            if (line_active && group_slot != '0) begin
                flush_group();
            end
            clear_line();
        end else if (line_chars >= uuds_pkg::LINE_LIMIT) begin
            clear_line();
            failed = 1'b1;
            push_result(8'd0, uuds_pkg::KIND_ERROR);
        end else begin
            line_chars++;
            if (line_chars == 1) begin
                line_active = (c > uuds_pkg::CHAR_SPACE) && (c <= uuds_pkg::CHAR_COUNT_MAX);
                bytes_left  = line_active ? 6'(c - uuds_pkg::CHAR_SPACE) : '0;
            end else if (line_active) begin
                sextet = '0;
                if (group_broken || c < uuds_pkg::CHAR_SPACE
                    || c > uuds_pkg::CHAR_DATA_MAX) begin
                    group_broken = 1'b1;
                end else begin
                    sextet = 6'(c - uuds_pkg::CHAR_SPACE);
                end
                group_bits |= 24'(sextet) << (6 * group_slot[1:0]);
                group_slot++;
                if (group_slot >= 4) begin
                    flush_group();
                end
            end
        end
        if (caused_q.size() > 0) begin
            caused_q[caused_q.size() - 1].last_of_run = 1'b1;
        end
        foreach (caused_q[k]) begin
            decoded_q.push_back(caused_q[k]);
        end
    endfunction

    always @(posedge i_clk) begin
        uuds_pkg::t_result want;
        if (!i_rst_n) begin
            clear_line();
            running_total = '0;
            failed        = 1'b0;
            decoded_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                decode_char(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected result: byte %02h kind %0d total %0d last %0b",
                                 $realtime, i_out_result.out_byte, i_out_result.kind,
                                 i_out_result.byte_total, i_out_result.last_of_run);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_result.out_byte !== want.out_byte ||
                        i_out_result.kind !== want.kind ||
                        i_out_result.byte_total !== want.byte_total ||
                        i_out_result.last_of_run !== want.last_of_run) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: expected %02h %0d %0d %0b, got %02h %0d %0d %0b",
                                     $realtime, want.out_byte, want.kind, want.byte_total,
                                     want.last_of_run, i_out_result.out_byte,
                                     i_out_result.kind, i_out_result.byte_total,
                                     i_out_result.last_of_run);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_open_count <= decoded_q.size();
    end

endmodule

[sim/tb_uudecode_stream_unit.sv]
module tb_uudecode_stream_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 460;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    uuds_pkg::t_item   i_item;
    logic              o_valid;
    logic              i_ready;
    uuds_pkg::t_result o_result;

    int fail_count;
    int open_count;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    int stall_phase = 0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    uudecode_stream_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    uuds_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_result (o_result),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= (stall_phase % 4) != 3;
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] data_char();
        int c;
        if ($urandom_range(0, 15) == 0) begin
            do c = $urandom_range(0, 255); while (c == uuds_pkg::CHAR_NEWLINE);
        end else begin
            c = $urandom_range(32, 96);
        end
        return 8'(c);
    endfunction

    task automatic send_item(input logic [7:0] ch, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 3);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid            = 1'b1;
        i_item.text_char   = ch;
        i_item.end_of_text = eot;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (open_count != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    // long_kind: 0 no long line, 1 a line exactly at the limit, 2 a line over it.
    task automatic send_text(input int long_kind);
        int lines;
        int n;
        int len;
        int pick;
        if (long_kind != 0) begin
            send_item(8'(32 + $urandom_range(1, 45)), 1'b0);
            if (long_kind == 1) begin
                repeat (uuds_pkg::LINE_LIMIT - 1) send_item(data_char(), 1'b0);
                send_item(uuds_pkg::CHAR_NEWLINE, 1'b0);
            end else begin
                repeat (uuds_pkg::LINE_LIMIT + $urandom_range(0, 2)) begin
                    send_item(data_char(), 1'b0);
                end
                repeat ($urandom_range(1, 5)) send_item(8'($urandom), 1'b0);
                send_item(8'($urandom), 1'b1);
                return;
            end
        end
        lines = $urandom_range(1, 4);
        for (int l = 0; l < lines; l++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                do n = $urandom_range(0, 255);
                while (n == uuds_pkg::CHAR_NEWLINE
                       || (n > uuds_pkg::CHAR_SPACE && n <= uuds_pkg::CHAR_COUNT_MAX));
                send_item(8'(n), 1'b0);
                repeat ($urandom_range(0, 6)) send_item(data_char(), 1'b0);
            end else begin
                n   = (pick == 1) ? $urandom_range(13, 45) : $urandom_range(1, 12);
                len = 4 * ((n + 2) / 3);
                case ($urandom_range(0, 5))
                    0: len = $urandom_range(0, len - 1);
                    1: len = len + $urandom_range(1, 6);
                    default: ;
                endcase
                send_item(8'(32 + n), 1'b0);
                repeat (len) send_item(data_char(), 1'b0);
            end
            if (l < lines - 1 || $urandom_range(0, 3) != 0) begin
                send_item(uuds_pkg::CHAR_NEWLINE, 1'b0);
            end
        end
        send_item(8'($urandom), 1'b1);
    endtask

    initial begin
        logic [8:0] directed_items[24];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        directed_items = '{
            9'h100,
            9'h021, 9'h020, 9'h03F, 9'h05F, 9'h060, {1'b0, uuds_pkg::CHAR_NEWLINE},
            9'h04D, 9'h000, 9'h041, 9'h061, 9'h01F, 9'h060, 9'h07F,
            {1'b0, uuds_pkg::CHAR_NEWLINE},
            9'h020, 9'h0FF, {1'b0, uuds_pkg::CHAR_NEWLINE},
            9'h04E, 9'h080, {1'b0, uuds_pkg::CHAR_NEWLINE},
            9'h023, 9'h055, 9'h1FF
        };
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_items[k]) begin
            send_item(directed_items[k][7:0], directed_items[k][8]);
        end
        wait_drained();

        for (int t = 0; items_sent < ITEM_TARGET; t++) begin
            send_text((t == 1) ? 2 : ((t == 4) ? 1 : 0));
            if ($urandom_range(0, 4) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && open_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/uuds_pkg.sv
hdl/uuds_decoder.sv
hdl/uuds_sequencer.sv
hdl/uudecode_stream_unit.sv
hdl/uuds_checker.sv
sim/uuds_checker.sv
sim/tb_uudecode_stream_unit.sv
